// File: hdl/kcar_pkg.sv
// Package for the keyed cache with aging replacement.
// Shared constants, result/item types and controller states.
// No dependencies.
package kcar_pkg;

  localparam int CAPACITY   = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NUM_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 32;
  localparam int DATA_W     = 64;
  localparam int SLOT_W     = 4;
  localparam int LIMIT_W    = 5;
  localparam int ADDR_W     = 3;
  localparam int APB_W      = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // request modes
  localparam logic MODE_STORE    = 1'b0;
  localparam logic MODE_RETRIEVE = 1'b1;

  // register select (word bit of paddr)
  localparam logic REG_LIMIT = 1'b0;

  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] payload;
  } kcar_item_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_data;
    logic [SLOT_W-1:0] slot_used;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic              stored;
  } kcar_result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_RD_HIT,
    S_BUMP,
    S_RD_CNT,
    S_HALVE,
    S_ABOVE,
    S_WRITE,
    S_HAND,
    S_DONE
  } state_t;

endpackage

// File: hdl/kcar_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on kcar_pkg.
interface kcar_req_if import kcar_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] payload;
  modport source (output valid, mode, key, payload, input ready);
  modport sink   (input valid, mode, key, payload, output ready);
endinterface

interface kcar_rsp_if import kcar_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_data;
  logic [SLOT_W-1:0] slot_used;
  logic              evicted;
  logic [KEY_W-1:0]  evicted_key;
  logic              stored;
  modport source (output valid, hit, read_data, slot_used, evicted, evicted_key, stored,
                  input ready);
  modport sink   (input valid, hit, read_data, slot_used, evicted, evicted_key, stored,
                  output ready);
endinterface

// File: hdl/kcar_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No package dependency.
module kcar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/kcar_ctrl.sv
// Cache sequencer: key scan, hit/fill/evict decision, aging sweep, hand update.
// Depends on kcar_pkg and kcar_ram.
module kcar_ctrl import kcar_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  kcar_item_t         item,
  input  logic [LIMIT_W-1:0] cache_limit,
  output logic               res_valid,
  input  logic               res_ready,
  output kcar_result_t       res
);

  state_t state, state_next;

  // latched request and control state
  kcar_item_t         ik;
  logic [NUM_W-1:0]   limit_l;
  logic [NUM_W-1:0]   entry_count;
  logic [KEY_W-1:0]   hand_key;
  logic               hand_at_end;
  logic [IDX_W-1:0]   h;
  logic [KEY_W-1:0]   hk;
  logic               ev;

  // scan engine
  logic [NUM_W-1:0]   scan_idx;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;
  logic [KEY_W-1:0]   cmp_key;
  logic               cmp_gt;
  logic               found;
  logic [IDX_W-1:0]   pos;
  logic               best_v;
  logic [IDX_W-1:0]   best_idx;
  logic [KEY_W-1:0]   best_key;
  logic               min_v;
  logic [IDX_W-1:0]   min_idx;
  logic [KEY_W-1:0]   min_key;

  logic               scan_on, scan_issue, scan_done, scan_start, cand;

  // memories
  logic [KEY_W-1:0]      key_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_wdata, cnt_half;
  logic [DATA_W-1:0]     pay_q;
  logic                  key_we, cnt_we, pay_we;

  kcar_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY), .AW(IDX_W)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(h), .wdata(ik.key),
    .raddr(scan_idx[IDX_W-1:0]), .rdata(key_q)
  );

  kcar_ram #(.WIDTH(COUNT_BITS), .DEPTH(CAPACITY), .AW(IDX_W)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(h), .wdata(cnt_wdata),
    .raddr(h), .rdata(cnt_q)
  );

  kcar_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY), .AW(IDX_W)) u_pay_ram (
    .clk(clk), .we(pay_we), .waddr(h), .wdata(ik.payload),
    .raddr(h), .rdata(pay_q)
  );

  assign cnt_half   = cnt_q >> 1;
  assign scan_on    = (state == S_LOOK) || (state == S_ABOVE) || (state == S_HAND);
  assign scan_issue = scan_on && (scan_idx < entry_count);
  assign scan_done  = scan_on && !scan_issue && !rd_pend;
  assign cand       = cmp_gt ? (key_q > cmp_key) : (key_q >= cmp_key);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (item_valid) state_next = S_LOOK;
      S_LOOK:   if (scan_done) state_next = S_DECIDE;
      S_DECIDE: begin
        if (ik.mode == MODE_RETRIEVE) begin
          state_next = found ? S_RD_HIT : S_DONE;
        end else if (limit_l == '0) begin
          state_next = S_DONE;
        end else if (found || (entry_count < limit_l)) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_RD_CNT;
        end
      end
      S_RD_HIT: state_next = S_BUMP;
      S_BUMP:   state_next = S_DONE;
      S_RD_CNT: state_next = S_HALVE;
      S_HALVE:  state_next = (cnt_half == '0) ? S_WRITE : S_ABOVE;
      S_ABOVE:  if (scan_done) state_next = S_RD_CNT;
      S_WRITE:  state_next = ev ? S_HAND : S_DONE;
      S_HAND:   if (scan_done) state_next = S_DONE;
      S_DONE:   if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    item_ready = (state == S_IDLE);
    res_valid  = (state == S_DONE);
    key_we     = (state == S_WRITE);
    pay_we     = (state == S_WRITE);
    cnt_we     = (state == S_WRITE) || (state == S_BUMP) || (state == S_HALVE);
    scan_start = ((state == S_IDLE) && item_valid) ||
                 ((state == S_HALVE) && (cnt_half != '0)) ||
                 ((state == S_WRITE) && ev);
    unique case (state)
      S_BUMP:  cnt_wdata = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
      S_HALVE: cnt_wdata = cnt_half;
      default: cnt_wdata = COUNT_BITS'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan over stored keys: match, nearest key >= (or >) compare key, smallest key
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (scan_start) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
      found    <= 1'b0;
      best_v   <= 1'b0;
      min_v    <= 1'b0;
      unique case (state)
        S_IDLE:  begin cmp_key <= hand_key; cmp_gt <= 1'b0; end
        default: begin cmp_key <= hk;       cmp_gt <= 1'b1; end
      endcase
    end else if (scan_on) begin
      rd_pend <= scan_issue;
      if (scan_issue) begin
        rd_idx   <= scan_idx[IDX_W-1:0];
        scan_idx <= scan_idx + NUM_W'(1);
      end
      if (rd_pend) begin
        if (key_q == ik.key) begin
          found <= 1'b1;
          pos   <= rd_idx;
        end
        if (cand && (!best_v || (key_q < best_key))) begin
          best_v   <= 1'b1;
          best_idx <= rd_idx;
          best_key <= key_q;
        end
        if (!min_v || (key_q < min_key)) begin
          min_v   <= 1'b1;
          min_idx <= rd_idx;
          min_key <= key_q;
        end
      end
    end
  end

  // request datapath and cache bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      hand_key    <= '0;
      hand_at_end <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            ik <= item;
            if (int'(cache_limit) > CAPACITY) begin
              limit_l <= NUM_W'(CAPACITY);
            end else begin
              limit_l <= NUM_W'(cache_limit);
            end
          end
        end
        S_DECIDE: begin
          res.hit         <= found && ((ik.mode == MODE_RETRIEVE) || (limit_l != '0));
          res.read_data   <= '0;
          res.slot_used   <= '0;
          res.evicted     <= 1'b0;
          res.evicted_key <= '0;
          res.stored      <= 1'b0;
          ev              <= 1'b0;
          if (found) begin
            h <= pos;
          end else if (entry_count < limit_l) begin
            h <= entry_count[IDX_W-1:0];
            if ((ik.mode == MODE_STORE) && (limit_l != '0)) begin
              entry_count <= entry_count + NUM_W'(1);
            end
          end else if (!hand_at_end && best_v) begin
            h  <= best_idx;
            hk <= best_key;
          end else begin
            h  <= min_idx;
            hk <= min_key;
          end
        end
        S_BUMP: begin
          res.read_data <= pay_q;
          res.slot_used <= SLOT_W'(h);
        end
        S_HALVE: begin
          if (cnt_half == '0) begin
            ev <= 1'b1;
          end
        end
        S_ABOVE: begin
          if (scan_done) begin
            if (best_v) begin
              h  <= best_idx;
              hk <= best_key;
            end else begin
              h  <= min_idx;
              hk <= min_key;
            end
          end
        end
        S_WRITE: begin
          res.stored      <= 1'b1;
          res.slot_used   <= SLOT_W'(h);
          res.evicted     <= ev;
          res.evicted_key <= ev ? hk : '0;
        end
        S_HAND: begin
          if (scan_done) begin
            hand_at_end <= !best_v;
            hand_key    <= best_v ? best_key : '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/keyed_cache_aging_replacement_top.sv
// Keyed cache with aging replacement, top level. A key scan reads one stored entry a
// cycle. A full-cache store first runs the aging hand, which halves counts until one
// reaches zero, and evicts that entry. One word at a time; the next word can enter in
// the cycle after the result moves into the output register, even while that result
// waits.
// Reset (rst, synchronous) empties the cache and parks the hand; no clearing pass.
module keyed_cache_aging_replacement_top import kcar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  kcar_req_if.sink          req,
  kcar_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  logic [LIMIT_W-1:0] cache_limit;
  kcar_item_t         item;
  kcar_result_t       res, res_q;
  logic               res_valid, res_ready;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIMIT) ? APB_W'(cache_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
      cache_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign item.mode    = req.mode;
  assign item.key     = req.key;
  assign item.payload = req.payload;

  kcar_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(req.valid), .item_ready(req.ready), .item(item),
    .cache_limit(cache_limit),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // output register
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign rsp.hit         = res_q.hit;
  assign rsp.read_data   = res_q.read_data;
  assign rsp.slot_used   = res_q.slot_used;
  assign rsp.evicted     = res_q.evicted;
  assign rsp.evicted_key = res_q.evicted_key;
  assign rsp.stored      = res_q.stored;

endmodule

// File: test/tb.sv
// Testbench for the keyed cache with aging replacement: random and directed
// store/retrieve words, checked against a cycle-free predictor in a scoreboard.
// Depends on kcar_pkg, kcar_req_if/kcar_rsp_if and keyed_cache_aging_replacement_top.
`timescale 1ns / 1ps

module tb;
  import kcar_pkg::*;

  localparam int COUNT_TOP  = (1 << COUNT_BITS) - 1;
  localparam int IDLE_LIMIT = 200000;

  // Scoreboard: holds its own copy of the cache and the queue of expected words
  class cache_scoreboard;
    logic [KEY_W-1:0]      keys [CAPACITY];
    int                    counts [CAPACITY];
    logic [DATA_W-1:0]     words [CAPACITY];
    int                    fill;
    logic [KEY_W-1:0]      hand;
    bit                    hand_end;
    logic [LIMIT_W-1:0]    limit;
    kcar_result_t          pending [$];
    int                    errors;

    function new();
      fill = 0;
      hand = '0;
      hand_end = 1;
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function int find_key(logic [KEY_W-1:0] k);
      for (int i = 0; i < fill; i++)
        if (keys[i] == k) return i;
      return -1;
    endfunction

    // smallest key >= k, or > k when above is set
    function int next_key(logic [KEY_W-1:0] k, bit above);
      int best;
      best = -1;
      for (int i = 0; i < fill; i++)
        if (above ? (keys[i] > k) : (keys[i] >= k))
          if (best < 0 || keys[i] < keys[best]) best = i;
      return best;
    endfunction

    function void note_request(kcar_item_t it);
      kcar_result_t r;
      int cap;
      int pos;
      int h;
      int guard;
      int nxt;
      r = '0;
      cap = (limit > CAPACITY) ? CAPACITY : int'(limit);
      pos = find_key(it.key);
      if (it.mode == MODE_RETRIEVE) begin
        if (pos >= 0) begin
          if (counts[pos] < COUNT_TOP) counts[pos]++;
          r.hit = 1;
          r.slot_used = SLOT_W'(pos);
          r.read_data = words[pos];
        end
      end else if (cap != 0) begin
        r.stored = 1;
        if (pos >= 0) begin
          r.hit = 1;
        end else if (fill < cap) begin
          pos = fill;
          fill++;
        end else begin
          // aging sweep: halve counts until one reaches zero
          guard = (fill + 1) * (COUNT_BITS + 2);
          h = hand_end ? -1 : next_key(hand, 0);
          forever begin
            if (h < 0) h = next_key('0, 0);
            if (h < 0) break;
            counts[h] = counts[h] >> 1;
            if (counts[h] == 0 || guard == 0) break;
            guard--;
            h = next_key(keys[h], 1);
          end
          if (h < 0) begin
            h = 0;
            fill = 1;
          end
          pos = h;
          r.evicted = 1;
          r.evicted_key = keys[h];
        end
        keys[pos] = it.key;
        counts[pos] = 1;
        words[pos] = it.payload;
        r.slot_used = SLOT_W'(pos);
        if (r.evicted) begin
          nxt = next_key(r.evicted_key, 1);
          if (nxt < 0) begin
            hand_end = 1;
            hand = '0;
          end else begin
            hand_end = 0;
            hand = keys[nxt];
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_response(kcar_result_t got);
      kcar_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response word %p", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit != want.hit) begin
        $display("%0t: hit exp %0h got %0h", $realtime, want.hit, got.hit);
        errors++;
      end
      if (got.read_data != want.read_data) begin
        $display("%0t: read_data exp %0h got %0h", $realtime, want.read_data, got.read_data);
        errors++;
      end
      if (got.slot_used != want.slot_used) begin
        $display("%0t: slot_used exp %0h got %0h", $realtime, want.slot_used, got.slot_used);
        errors++;
      end
      if (got.evicted != want.evicted) begin
        $display("%0t: evicted exp %0h got %0h", $realtime, want.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key != want.evicted_key) begin
        $display("%0t: evicted_key exp %0h got %0h", $realtime, want.evicted_key,
                 got.evicted_key);
        errors++;
      end
      if (got.stored != want.stored) begin
        $display("%0t: stored exp %0h got %0h", $realtime, want.stored, got.stored);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  kcar_req_if req ();
  kcar_rsp_if rsp ();

  keyed_cache_aging_replacement_top uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cache_scoreboard sb;
  bit req_fire;
  bit rsp_fire;
  int idle_cycles;
  bit stim_done;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // handshakes are sampled mid-cycle, ahead of the edge that completes them
  always @(negedge clk) begin
    req_fire = req.valid && req.ready;
    rsp_fire = rsp.valid && rsp.ready;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (req_fire || rsp_fire || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("keyed_cache_aging_replacement_top verification failed");
      $finish;
    end
  end

  // response sink with random stalls
  initial begin
    int stall;
    rsp.ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1;
      forever begin
        @(negedge clk);
        if (rsp.valid) break;
      end
      sb.check_response(kcar_result_t'({rsp.hit, rsp.read_data, rsp.slot_used,
                                        rsp.evicted, rsp.evicted_key, rsp.stored}));
      @(posedge clk);
    end
  end

  int burst;

  task automatic send_word(logic mode, logic [KEY_W-1:0] key, logic [DATA_W-1:0] payload);
    int gap;
    kcar_item_t it;
    gap = (burst > 0) ? 0 : $urandom_range(0, 5);
    if (burst > 0) burst--;
    else if ($urandom_range(0, 15) == 0) burst = $urandom_range(5, 20);
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1;
    req.mode    <= mode;
    req.key     <= key;
    req.payload <= payload;
    it.mode = mode;
    it.key = key;
    it.payload = payload;
    forever begin
      @(negedge clk);
      if (req.ready) break;
    end
    @(posedge clk);
    sb.note_request(it);
  endtask

  // waits until the cache has answered everything, then lets it settle
  task automatic drain();
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    drain();
    psel    <= 1;
    pwrite  <= 1;
    penable <= 0;
    paddr   <= ADDR_W'(4 * REG_LIMIT);
    pwdata  <= APB_W'(value);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    sb.limit = value;
    @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 7);
      default: return $urandom_range(0, 23);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [DATA_W-1:0] pl;
    for (int i = 0; i < n; i++) begin
      pl = {$urandom, $urandom};
      send_word(($urandom_range(0, 9) < 4) ? MODE_STORE : MODE_RETRIEVE, pick_key(), pl);
    end
  endtask

  initial begin
    sb = new();
    burst = 0;
    stim_done = 0;
    idle_cycles = 0;
    req_fire = 0;
    rsp_fire = 0;
    rst = 1;
    req.valid = 0;
    req.mode = MODE_STORE;
    req.key = '0;
    req.payload = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: key and payload extremes, hits, misses, overwrite
    send_word(MODE_RETRIEVE, 32'd0, '0);
    send_word(MODE_STORE, 32'd0, '0);
    send_word(MODE_STORE, 32'hFFFF_FFFF, '1);
    send_word(MODE_RETRIEVE, 32'hFFFF_FFFF, 64'h1234);
    send_word(MODE_RETRIEVE, 32'd0, '1);
    send_word(MODE_RETRIEVE, 32'd5, '0);
    send_word(MODE_STORE, 32'd0, 64'hA5A5_5A5A_F00D_BEEF);
    send_word(MODE_RETRIEVE, 32'd0, '0);
    // limit zero: stores do nothing
    write_limit(5'd0);
    send_word(MODE_STORE, 32'd7, '1);
    send_word(MODE_RETRIEVE, 32'd7, '0);
    // single entry: every absent store evicts, hand wraps
    write_limit(5'd1);
    send_word(MODE_STORE, 32'd9, 64'd9);
    send_word(MODE_STORE, 32'd3, 64'd3);
    send_word(MODE_RETRIEVE, 32'd3, '0);
    send_word(MODE_STORE, 32'd4, 64'd4);
    // limit above capacity is clamped
    write_limit(5'd31);
    for (int i = 0; i < 10; i++) send_word(MODE_STORE, 32'(100 + i), {$urandom, $urandom});

    // random phases over several limits, including lowering below the fill
    write_limit(5'd16);
    random_phase(200);
    write_limit(5'd3);
    random_phase(120);
    write_limit(5'd31);
    random_phase(150);
    write_limit(5'd0);
    random_phase(40);
    write_limit(5'd1);
    random_phase(60);
    write_limit(5'd8);
    random_phase(120);
    for (int p = 0; p < 4; p++) begin
      write_limit(LIMIT_W'($urandom_range(0, 31)));
      random_phase(70);
    end

    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("keyed_cache_aging_replacement_top verification clean");
    else
      $display("keyed_cache_aging_replacement_top verification failed");
    $finish;
  end

endmodule
